FILE: rtl/bite_pkg.sv
package bite_pkg;

  localparam int OP_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int INDEX_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int FOUND_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(64);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MODIFY = 3'd2,
    OP_FIND   = 3'd3,
    OP_SORT   = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPARAM = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

FILE: rtl/bite_ram.sv
module bite_ram
  import bite_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [VALUE_W-1:0] rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/bounded_int_table_engine.sv
// Channel   Ports                                           Handshake
// request   in_operation, in_value, in_index                start & !busy
// result    out_status, out_found_index, out_element_count  out_valid, one cycle
// config    cfg_wdata (capacity)                            cfg_we
//
// Append, modify and rejected requests finish from idle; remove reads the last entry first.
// Find reads one entry per cycle through the single RAM read port, up to the first match.
// Sort runs bubble passes over the RAM, one compare-swap per cycle, with a load state
// before each pass and a write-back of the carried largest entry after it.
// Synchronous reset clears count and capacity (to 64); RAM contents are not cleared.
// The result is shown for exactly one cycle; the receiver cannot stall it.
module bounded_int_table_engine
  import bite_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [VALUE_W-1:0]  in_value,
  input  logic [INDEX_W-1:0]  in_index,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [FOUND_W-1:0]  out_found_index,
  output logic [COUNT_W-1:0]  out_element_count,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int XW = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_REM        = 6'b000010,
    S_FIND       = 6'b000100,
    S_SORT_FIRST = 6'b001000,
    S_SORT_RUN   = 6'b010000,
    S_SORT_END   = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   capacity_r;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [AW-1:0]        last_r, last_nxt;
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [VALUE_W-1:0]   carry_r, carry_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [FOUND_W-1:0]   found_r, found_nxt;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [VALUE_W-1:0]   wr_data, rd_data;

  logic [XW-1:0]        cnt_ext, last_ext, idx_ext, ptr_ext;
  logic [AW-1:0]        cnt_addr, last_addr, idx_addr;
  logic                 full, idx_bad, sort_gt;

  bite_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cnt_ext   = XW'(count_r);
  assign cnt_addr  = cnt_ext[AW-1:0];
  assign last_ext  = cnt_ext - XW'(1);
  assign last_addr = last_ext[AW-1:0];
  assign idx_ext   = XW'(in_index);
  assign idx_addr  = idx_ext[AW-1:0];
  assign ptr_ext   = XW'(ptr_r);
  assign idx_bad   = idx_ext >= cnt_ext;
  // effective capacity saturates at DEPTH
  assign full      = (count_r >= capacity_r) || (cnt_ext >= XW'(DEPTH));
  assign sort_gt   = $signed(carry_r) > $signed(rd_data);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    val_nxt       = val_r;
    carry_nxt     = carry_r;
    out_valid_nxt = 1'b0;
    status_nxt    = ST_OK;
    found_nxt     = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op_t'(in_operation))
            OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = cnt_addr;
                wr_data   = in_value;
                count_nxt = count_r + COUNT_W'(1);
              end
            end
            OP_REMOVE: begin
              if (idx_bad) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_BADPARAM;
              end else begin
                // fetch the last entry to fill the hole
                rd_en     = 1'b1;
                rd_addr   = last_addr;
                idx_nxt   = idx_addr;
                state_nxt = S_REM;
              end
            end
            OP_MODIFY: begin
              out_valid_nxt = 1'b1;
              if (idx_bad) begin
                status_nxt = ST_BADPARAM;
              end else begin
                wr_en   = 1'b1;
                wr_addr = idx_addr;
                wr_data = in_value;
              end
            end
            OP_FIND: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = ST_NOTFOUND;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                val_nxt   = in_value;
                ptr_nxt   = '0;
                last_nxt  = last_addr;
                state_nxt = S_FIND;
              end
            end
            OP_SORT: begin
              if (count_r < COUNT_W'(2)) begin
                out_valid_nxt = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                last_nxt  = last_addr;
                state_nxt = S_SORT_FIRST;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              status_nxt    = ST_BADPARAM;
            end
          endcase
        end
      end
      S_REM: begin
        wr_en         = 1'b1;
        wr_addr       = idx_r;
        wr_data       = rd_data;
        count_nxt     = count_r - COUNT_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_FIND: begin
        if (rd_data == val_r) begin
          out_valid_nxt = 1'b1;
          found_nxt     = ptr_ext[FOUND_W-1:0];
          state_nxt     = S_IDLE;
        end else if (ptr_r == last_r) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_NOTFOUND;
          state_nxt     = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(1);
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_SORT_FIRST: begin
        carry_nxt = rd_data;
        rd_en     = 1'b1;
        rd_addr   = AW'(1);
        ptr_nxt   = '0;
        state_nxt = S_SORT_RUN;
      end
      S_SORT_RUN: begin
        // write back the smaller, carry the larger up the pass
        wr_en     = 1'b1;
        wr_addr   = ptr_r;
        wr_data   = sort_gt ? rd_data : carry_r;
        carry_nxt = sort_gt ? carry_r : rd_data;
        if ((ptr_r + AW'(1)) == last_r) begin
          state_nxt = S_SORT_END;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(2);
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      S_SORT_END: begin
        wr_en   = 1'b1;
        wr_addr = last_r;
        wr_data = carry_r;
        if (last_r == AW'(1)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          last_nxt  = last_r - AW'(1);
          state_nxt = S_SORT_FIRST;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    ptr_r       <= ptr_nxt;
    last_r      <= last_nxt;
    val_r       <= val_nxt;
    carry_r     <= carry_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    out_count_r <= count_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found_index   = found_r;
  assign out_element_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    XW'(count_r) <= XW'(DEPTH))
    else $error("element count beyond table depth");

  a_done_reports: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("multi-cycle request ended without a result");

  a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> out_valid_r)
    else $error("count changed without a result");

  a_remove_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM) |-> (XW'(idx_r) < cnt_ext))
    else $error("remove slot beyond count");

endmodule

FILE: test/tb.sv
module tb;
  import bite_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FOUND_W-1:0]  found_index;
    logic [COUNT_W-1:0]  element_count;
  } table_result_t;

  class table_scoreboard;
    logic [VALUE_W-1:0] entries [TABLE_DEPTH];
    int                 count;
    int                 capacity;
    table_result_t      expected_results [$];
    int unsigned        mismatches;

    function new();
      count      = 0;
      capacity   = 64;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [COUNT_W-1:0] c);
      capacity = c;
    endfunction

    // Apply one accepted request to the table copy and queue its result.
    function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                               logic [INDEX_W-1:0] index);
      table_result_t      res;
      int                 limit;
      logic [VALUE_W-1:0] swap;
      res.status      = ST_OK;
      res.found_index = '0;
      limit = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
      case (op)
        OP_APPEND: begin
          if (count >= limit) begin
            res.status = ST_FULL;
          end else begin
            entries[count] = value;
            count++;
          end
        end
        OP_REMOVE: begin
          if (int'(index) >= count) begin
            res.status = ST_BADPARAM;
          end else begin
            entries[index] = entries[count-1];
            count--;
          end
        end
        OP_MODIFY: begin
          if (int'(index) >= count) res.status = ST_BADPARAM;
          else entries[index] = value;
        end
        OP_FIND: begin
          res.status = ST_NOTFOUND;
          for (int i = 0; i < count; i++) begin
            if (entries[i] == value) begin
              res.status      = ST_OK;
              res.found_index = FOUND_W'(i);
              break;
            end
          end
        end
        OP_SORT: begin
          for (int i = 0; i < count - 1; i++) begin
            for (int j = 0; j < count - 1 - i; j++) begin
              if ($signed(entries[j]) > $signed(entries[j+1])) begin
                swap         = entries[j];
                entries[j]   = entries[j+1];
                entries[j+1] = swap;
              end
            end
          end
        end
        default: res.status = ST_BADPARAM;
      endcase
      res.element_count = COUNT_W'(count);
      expected_results.push_back(res);
    endfunction

    function void report(string what, table_result_t want, table_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected status %0d found_index %0d count %0d, %s %0d %s %0d %s %0d",
                 $time, what, want.status, want.found_index, want.element_count,
                 "got status", got.status, "found_index", got.found_index,
                 "count", got.element_count);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [FOUND_W-1:0] fi,
                               logic [COUNT_W-1:0] ec);
      table_result_t got;
      table_result_t want;
      got.status        = st;
      got.found_index   = fi;
      got.element_count = ec;
      if (expected_results.size() == 0) begin
        report("result with no request pending", '0, got);
        return;
      end
      want = expected_results.pop_front();
      if (st !== want.status || fi !== want.found_index || ec !== want.element_count)
        report("wrong result", want, got);
    endfunction

    function void flush_leftovers();
      while (expected_results.size() != 0)
        report("result never arrived", expected_results.pop_front(), '0);
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     in_operation;
  logic [VALUE_W-1:0]  in_value;
  logic [INDEX_W-1:0]  in_index;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [FOUND_W-1:0]  out_found_index;
  logic [COUNT_W-1:0]  out_element_count;
  logic                cfg_we;
  logic [COUNT_W-1:0]  cfg_wdata;

  table_scoreboard sb;

  bounded_int_table_engine #(.DEPTH(TABLE_DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_index          (in_index),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_found_index   (out_found_index),
    .out_element_count (out_element_count),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_found_index, out_element_count);
  end

  // Call at a falling edge; returns at the falling edge after acceptance with start held.
  task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [INDEX_W-1:0] index);
    in_operation = op;
    in_value     = value;
    in_index     = index;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(op, value, index);
    @(negedge clk);
  endtask

  task automatic idle_gap(int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start        = 1'b0;
      in_operation = OP_W'($urandom);
      in_value     = $urandom;
      in_index     = INDEX_W'($urandom);
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sb.expected_results.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_capacity(logic [COUNT_W-1:0] c);
    wait_drained();
    cfg_wdata = c;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_capacity(c);
  endtask

  function automatic logic [INDEX_W-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(99);
    if (sb.count > 0 && r < 85) return INDEX_W'($urandom_range(sb.count - 1));
    if (r < 95) return INDEX_W'($urandom_range(255));
    return INDEX_W'(sb.count);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return VALUE_W'($urandom_range(6)) - VALUE_W'(3);
    if (r < 40) begin
      case ($urandom_range(3))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    // reuse a stored value so finds hit and duplicates pile up
    if (r < 65 && sb.count > 0) return sb.entries[$urandom_range(sb.count - 1)];
    return $urandom;
  endfunction

  task automatic run_random_phase(logic [COUNT_W-1:0] cap, int unsigned idle_pct,
                                  int unsigned n, int unsigned append_pct);
    logic [OP_W-1:0] op;
    int unsigned     r;
    write_capacity(cap);
    for (int unsigned k = 0; k < n; k++) begin
      idle_gap(idle_pct);
      if ($urandom_range(99) < append_pct) begin
        op = OP_APPEND;
      end else begin
        r = $urandom_range(99);
        if (r < 25)      op = OP_REMOVE;
        else if (r < 50) op = OP_MODIFY;
        else if (r < 88) op = OP_FIND;
        else if (r < 94) op = OP_SORT;
        else             op = OP_W'($urandom_range(5, 7));
      end
      send_request(op, pick_value(), pick_index());
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = '0;
    in_value     = '0;
    in_index     = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table corner cases, then signed extremes, bad indices and undefined opcodes
    send_request(OP_FIND,   32'd5, 8'd0);
    send_request(OP_SORT,   32'd0, 8'd0);
    send_request(OP_REMOVE, 32'd0, 8'd0);
    send_request(OP_MODIFY, 32'd1, 8'd0);
    send_request(OP_APPEND, 32'h7fff_ffff, 8'd0);
    send_request(OP_SORT,   32'd0, 8'd0);
    send_request(OP_APPEND, 32'h8000_0000, 8'd0);
    send_request(OP_APPEND, 32'hffff_ffff, 8'd0);
    send_request(OP_APPEND, 32'h0000_0000, 8'd0);
    send_request(OP_APPEND, 32'hffff_ffff, 8'd0);
    send_request(OP_FIND,   32'hffff_ffff, 8'd0);
    send_request(OP_FIND,   32'd12345, 8'd0);
    send_request(OP_MODIFY, 32'd7, 8'd255);
    send_request(OP_MODIFY, 32'h8000_0000, 8'd4);
    send_request(OP_REMOVE, 32'd0, 8'd5);
    send_request(OP_REMOVE, 32'd0, 8'd0);
    send_request(OP_W'(5), 32'd0, 8'd0);
    send_request(OP_W'(6), 32'hffff_ffff, 8'd0);
    send_request(OP_W'(7), 32'd0, 8'd255);
    send_request(OP_SORT,   32'd0, 8'd0);
    send_request(OP_FIND,   32'h8000_0000, 8'd0);

    // capacity dropped below the current count
    write_capacity(COUNT_W'(2));
    send_request(OP_APPEND, 32'd9, 8'd0);
    send_request(OP_REMOVE, 32'd0, 8'd3);
    send_request(OP_REMOVE, 32'd0, 8'd0);
    send_request(OP_APPEND, 32'd9, 8'd0);
    send_request(OP_REMOVE, 32'd0, 8'd1);
    send_request(OP_APPEND, 32'd9, 8'd0);

    run_random_phase(COUNT_W'(64),  0,  400, 45);
    run_random_phase(COUNT_W'(127), 76, 300, 70);
    run_random_phase(COUNT_W'(8),   19, 400, 30);
    run_random_phase(COUNT_W'(1),   0,  150, 40);
    run_random_phase(COUNT_W'(0),   76, 100, 40);
    run_random_phase(COUNT_W'(20),  19, 450, 45);

    wait_drained();
    repeat (50) @(negedge clk);
    sb.flush_leftovers();
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: bounded_int_table_engine.f
rtl/bite_pkg.sv
rtl/bite_ram.sv
rtl/bounded_int_table_engine.sv
test/tb.sv
